FILE: hw/rtl/hsd_pkg.sv
// Shared types and constants for the heel strike detector with cycle average.
// No dependencies; used by every module of the block.
package hsd_pkg;

  localparam int AvgCyclesDefault = 5;

  localparam int CfgIdxW = 2;
  localparam int CfgW    = 23;

  localparam logic [CfgIdxW-1:0] RegHeightLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRiseMargin  = 2'd1;

  localparam logic [CfgW-1:0]   HeightLimitReset = 23'd128000;
  localparam logic [CfgW-1:0]   RiseMarginReset  = 23'd25600;
  localparam logic signed [23:0] MinHeightReset  = -24'sd256000;

  typedef struct packed {
    logic        strike;
    logic [23:0] strike_frame;
    logic [31:0] cycle_count;
  } hsd_tag_t;

endpackage

FILE: hw/rtl/hsd_detect.sv
// Strike and arming detection, cycle duration ring and running sum.
// Depends on hsd_pkg; feeds the divide stages with the tag and the sum.
module hsd_detect #(
  parameter int AVG_CYCLES = hsd_pkg::AvgCyclesDefault,
  parameter int SUM_W      = 32 + $clog2(hsd_pkg::AvgCyclesDefault)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hsd_pkg::CfgW-1:0]   height_limit,
  input  logic [hsd_pkg::CfgW-1:0]   rise_margin,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [23:0]                frame,
  input  logic signed [23:0]         vert,
  input  logic signed [23:0]         sag,
  input  logic [31:0]                now,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output hsd_pkg::hsd_tag_t          dn_tag,
  output logic [SUM_W-1:0]           dn_sum
);
  import hsd_pkg::*;

  logic signed [24:0] vel_hist_1, vel_hist_2, vel_hist_3;
  logic signed [23:0] vert_prev_1, vert_prev_2, sag_prev, min_height;
  logic               armed;
  logic [31:0]        duration_ring [0:AVG_CYCLES-1];
  logic [SUM_W-1:0]   duration_sum;
  logic [31:0]        last_strike_time;
  logic [23:0]        strike_frame_reg;
  logic [31:0]        cycle_counter;

  logic               take;
  logic signed [24:0] vel_z, vel_s, rise;
  logic               strike_c, arm_c;
  logic [31:0]        dur;
  logic [SUM_W-1:0]   duration_sum_next;
  logic [23:0]        strike_frame_next;
  logic [31:0]        cycle_counter_next;

  assign up_ready = !dn_valid || dn_ready;
  assign take     = up_valid && up_ready;

  assign vel_z = {vert[23], vert} - {vert_prev_1[23], vert_prev_1};
  assign vel_s = {sag[23], sag} - {sag_prev[23], sag_prev};
  assign rise  = {vert_prev_2[23], vert_prev_2} - {min_height[23], min_height};

  assign strike_c = !vel_z[24]
                    && (vel_hist_1[24] || vel_hist_1 == '0)
                    && (vel_hist_2[24] || vel_hist_2 == '0)
                    && (vel_hist_3[24] || vel_hist_3 == '0)
                    && armed
                    && (vel_s[24] || vel_s == '0)
                    && ($signed({vert[23], vert}) < $signed({2'b00, height_limit}));

  assign arm_c = (frame > 24'd2)
                 && vel_z[24]
                 && (vel_hist_1[24] || vel_hist_1 == '0)
                 && !vel_hist_2[24]
                 && !vel_hist_3[24]
                 && (rise > $signed({2'b00, rise_margin}));

  assign dur = now - last_strike_time;

  always_comb begin
    duration_sum_next  = duration_sum;
    strike_frame_next  = strike_frame_reg;
    cycle_counter_next = cycle_counter;
    if (strike_c) begin
      duration_sum_next  = duration_sum - SUM_W'(duration_ring[0]) + SUM_W'(dur);
      strike_frame_next  = frame - 24'd1;
      cycle_counter_next = cycle_counter + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_hist_1       <= '0;
      vel_hist_2       <= '0;
      vel_hist_3       <= '0;
      vert_prev_1      <= '0;
      vert_prev_2      <= '0;
      sag_prev         <= '0;
      min_height       <= MinHeightReset;
      armed            <= 1'b0;
      duration_sum     <= '0;
      last_strike_time <= '0;
      strike_frame_reg <= '0;
      cycle_counter    <= 32'd1;
      dn_valid         <= 1'b0;
      for (int i = 0; i < AVG_CYCLES; i++) begin
        duration_ring[i] <= '0;
      end
    end else begin
      if (up_ready) begin
        dn_valid <= up_valid;
      end
      if (take) begin
        vel_hist_3       <= vel_hist_2;
        vel_hist_2       <= vel_hist_1;
        vel_hist_1       <= vel_z;
        vert_prev_2      <= vert_prev_1;
        vert_prev_1      <= vert;
        sag_prev         <= sag;
        duration_sum     <= duration_sum_next;
        strike_frame_reg <= strike_frame_next;
        cycle_counter    <= cycle_counter_next;
        if (strike_c) begin
          min_height       <= vert_prev_1;
          armed            <= 1'b0;
          last_strike_time <= now;
          for (int i = 0; i < AVG_CYCLES - 1; i++) begin
            duration_ring[i] <= duration_ring[i+1];
          end
          duration_ring[AVG_CYCLES-1] <= dur;
        end else if (arm_c) begin
          armed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dn_tag.strike       <= strike_c;
      dn_tag.strike_frame <= strike_frame_next;
      dn_tag.cycle_count  <= cycle_counter_next;
      dn_sum              <= duration_sum_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_strike_holds_totals: assert property (@(posedge clk) disable iff (rst)
    (take && !strike_c) |=> $stable(cycle_counter) && $stable(duration_sum))
    else $error("cycle totals changed without a strike");

  a_strike_reaches_stage: assert property (@(posedge clk) disable iff (rst)
    (take && strike_c) |=> dn_valid && dn_tag.strike && !armed)
    else $error("strike not passed downstream or arming left set");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && !dn_ready) |=> dn_valid && $stable(dn_tag) && $stable(dn_sum))
    else $error("detect stage word changed while held");
`endif

endmodule

FILE: hw/rtl/hsd_div_stage.sv
// Divide-by-AVG_CYCLES unit: the duration sum times a reciprocal constant, two registered steps.
// Depends on hsd_pkg; placed by the top level after hsd_detect.
module hsd_div_stage #(
  parameter int AVG_CYCLES = hsd_pkg::AvgCyclesDefault,
  parameter int SUM_W      = 32 + $clog2(hsd_pkg::AvgCyclesDefault)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsd_pkg::hsd_tag_t up_tag,
  input  logic [SUM_W-1:0]  up_sum,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsd_pkg::hsd_tag_t dn_tag,
  output logic [31:0]       dn_avg
);
  import hsd_pkg::*;

  localparam int Shift   = SUM_W + $clog2(AVG_CYCLES);
  localparam int RecipW  = SUM_W + 1;
  localparam int LoW     = (RecipW + 1) / 2;
  localparam int HiW     = RecipW - LoW;
  localparam int LoProdW = SUM_W + LoW;
  localparam int HiProdW = SUM_W + HiW;
  localparam int ProdW   = SUM_W + RecipW;

  // ceil(2^Shift / AVG_CYCLES): the product shifted by Shift is the exact
  // truncated quotient for every sum below 2^SUM_W
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(AVG_CYCLES) - 64'd1) / 64'(AVG_CYCLES);
  localparam logic [RecipW-1:0] Recip   = RecipFull[RecipW-1:0];
  localparam logic [LoW-1:0]    RecipLo = Recip[LoW-1:0];
  localparam logic [HiW-1:0]    RecipHi = Recip[RecipW-1:LoW];

  logic               s1_valid;
  logic               s2_ready;
  hsd_tag_t           s1_tag;
  logic [LoProdW-1:0] s1_lo;
  logic [HiProdW-1:0] s1_hi;
  logic [LoProdW-1:0] prod_lo;
  logic [HiProdW-1:0] prod_hi;
  logic [ProdW-1:0]   prod_sum;

  assign prod_lo  = LoProdW'(up_sum) * LoProdW'(RecipLo);
  assign prod_hi  = HiProdW'(up_sum) * HiProdW'(RecipHi);
  assign prod_sum = {s1_hi, {LoW{1'b0}}} + ProdW'(s1_lo);

  assign s2_ready = !dn_valid || dn_ready;
  assign up_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        s1_valid <= up_valid;
      end
      if (s2_ready) begin
        dn_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s1_tag <= up_tag;
      s1_lo  <= prod_lo;
      s1_hi  <= prod_hi;
    end
    if (s1_valid && s2_ready) begin
      dn_tag <= s1_tag;
      dn_avg <= prod_sum[Shift +: 32];
    end
  end

`ifndef ASSERT_OFF
  a_step_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=>
      s1_valid && $stable(s1_tag) && $stable(s1_lo) && $stable(s1_hi))
    else $error("partial products changed while held");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && !dn_ready) |=> dn_valid && $stable(dn_tag) && $stable(dn_avg))
    else $error("average word changed while held");

  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (prod_sum[ProdW-1:Shift+32] == '0))
    else $error("average does not fit 32 bits");
`endif

endmodule

FILE: hw/rtl/heel_strike_detector_cycle_average_top.sv
// Heel strike detector with average of the last AVG_CYCLES gait cycle durations.
// Depends on hsd_pkg, hsd_detect and hsd_div_stage.
// One sample word is taken per clock while in_stall is low, and one result word
// comes out per sample, in order. An accepted sample passes the input register,
// the detection stage, then two steps of the divide by AVG_CYCLES, which
// multiplies the duration sum by a reciprocal constant in two halves and adds
// the halves. Each stage holds its word under out_stall while earlier stages
// keep filling, so in_stall rises only when all four stages are occupied and
// out_stall is high. Configuration writes are always ready and apply to samples
// that reach detection after the write, so write only while no sample is in
// flight.
module heel_strike_detector_cycle_average_top #(
  parameter int AVG_CYCLES = hsd_pkg::AvgCyclesDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [hsd_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [23:0]                 frame_number,
  input  logic signed [23:0]          heel_vertical,
  input  logic signed [23:0]          heel_sagittal,
  input  logic [31:0]                 time_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        strike,
  output logic [23:0]                 strike_frame,
  output logic [31:0]                 cycle_avg_us,
  output logic [31:0]                 cycle_count
);
  import hsd_pkg::*;

  localparam int SumW = 32 + $clog2(AVG_CYCLES);

  logic [CfgW-1:0] height_limit, rise_margin;

  logic               in_reg_valid;
  logic [23:0]        in_frame;
  logic signed [23:0] in_vert, in_sag;
  logic [31:0]        in_time;
  logic               det_ready;
  logic               load;

  logic            det_valid;
  logic            div_ready;
  hsd_tag_t        det_tag;
  logic [SumW-1:0] det_sum;
  logic            out_ready;
  hsd_tag_t        out_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_limit <= HeightLimitReset;
      rise_margin  <= RiseMarginReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegHeightLimit: height_limit <= cfg_data;
        RegRiseMargin:  rise_margin  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = in_reg_valid && !det_ready;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (load) begin
      in_reg_valid <= 1'b1;
    end else if (det_ready) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_frame <= frame_number;
      in_vert  <= heel_vertical;
      in_sag   <= heel_sagittal;
      in_time  <= time_us;
    end
  end

  hsd_detect #(
    .AVG_CYCLES (AVG_CYCLES),
    .SUM_W      (SumW)
  ) u_detect (
    .clk          (clk),
    .rst          (rst),
    .height_limit (height_limit),
    .rise_margin  (rise_margin),
    .up_valid     (in_reg_valid),
    .up_ready     (det_ready),
    .frame        (in_frame),
    .vert         (in_vert),
    .sag          (in_sag),
    .now          (in_time),
    .dn_valid     (det_valid),
    .dn_ready     (div_ready),
    .dn_tag       (det_tag),
    .dn_sum       (det_sum)
  );

  hsd_div_stage #(
    .AVG_CYCLES (AVG_CYCLES),
    .SUM_W      (SumW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (det_valid),
    .up_ready (div_ready),
    .up_tag   (det_tag),
    .up_sum   (det_sum),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_tag   (out_tag),
    .dn_avg   (cycle_avg_us)
  );

  assign out_ready = !out_stall;

  assign strike       = out_tag.strike;
  assign strike_frame = out_tag.strike_frame;
  assign cycle_count  = out_tag.cycle_count;

endmodule

FILE: tb/sv/tb_heel_strike_detector_cycle_average_top.sv
// Self-checking bench for heel_strike_detector_cycle_average_top: gait-like sample
// streams with random flaws and noise, under random gaps and stalls, checked word by word.
// Depends on hsd_pkg and the RTL of the block; the strike predictor lives in a local class.
module tb_heel_strike_detector_cycle_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AvgN = hsd_pkg::AvgCyclesDefault;
  localparam int QuietLimit = 4000;
  localparam logic [hsd_pkg::CfgW-1:0] CfgMax = 23'h7FFFFF;
  localparam logic [hsd_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [hsd_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

  typedef struct {
    logic        strike;
    logic [23:0] frame;
    logic [31:0] average;
    logic [31:0] count;
  } gait_word_t;

  typedef enum int {
    FlawSagForward,
    FlawHighHeel,
    FlawShortFall,
    FlawLowPeak,
    FlawNoPlateau
  } flaw_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hsd_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [hsd_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [23:0] frame_number = '0;
  logic signed [23:0] heel_vertical = '0;
  logic signed [23:0] heel_sagittal = '0;
  logic [31:0] time_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic strike;
  logic [23:0] strike_frame;
  logic [31:0] cycle_avg_us;
  logic [31:0] cycle_count;

  class strike_scoreboard;
    logic [22:0] height_limit;
    logic [22:0] rise_margin;
    int vel_1, vel_2, vel_3;
    int vert_1, vert_2, sag_1;
    int min_height;
    bit armed;
    logic [31:0] durations [AvgN];
    logic [34:0] duration_total;
    logic [31:0] last_time;
    logic [23:0] last_frame;
    logic [31:0] average;
    logic [31:0] cycles;
    gait_word_t due_q[$];
    int errors;

    function new();
      height_limit = hsd_pkg::HeightLimitReset;
      rise_margin = hsd_pkg::RiseMarginReset;
      vel_1 = 0;
      vel_2 = 0;
      vel_3 = 0;
      vert_1 = 0;
      vert_2 = 0;
      sag_1 = 0;
      min_height = hsd_pkg::MinHeightReset;
      armed = 1'b0;
      for (int i = 0; i < AvgN; i++) durations[i] = '0;
      duration_total = '0;
      last_time = '0;
      last_frame = '0;
      average = '0;
      cycles = 32'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [hsd_pkg::CfgIdxW-1:0] idx, logic [22:0] value);
      case (idx)
        hsd_pkg::RegHeightLimit: height_limit = value;
        hsd_pkg::RegRiseMargin: rise_margin = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_sample(logic [23:0] frame, logic [23:0] vert_bits,
                              logic [23:0] sag_bits, logic [31:0] now);
      int vert, sag, vel_z, vel_s;
      logic [31:0] span;
      gait_word_t w;
      vert = $signed(vert_bits);
      sag = $signed(sag_bits);
      vel_z = vert - vert_1;
      vel_s = sag - sag_1;
      w.strike = 1'b0;
      if (vel_z >= 0 && vel_1 <= 0 && vel_2 <= 0 && vel_3 <= 0 && armed && vel_s <= 0 &&
          vert < int'(height_limit)) begin
        span = now - last_time;
        min_height = vert_1;
        last_frame = frame - 24'd1;
        last_time = now;
        duration_total = duration_total - durations[0] + span;
        for (int i = 0; i < AvgN - 1; i++) durations[i] = durations[i + 1];
        durations[AvgN - 1] = span;
        average = 32'(duration_total / AvgN);
        cycles = cycles + 32'd1;
        armed = 1'b0;
        w.strike = 1'b1;
      end else if (frame > 24'd2 && vel_z < 0 && vel_1 <= 0 && vel_2 >= 0 && vel_3 >= 0 &&
                   vert_2 - min_height > int'(rise_margin)) begin
        armed = 1'b1;
      end
      vel_3 = vel_2;
      vel_2 = vel_1;
      vel_1 = vel_z;
      vert_2 = vert_1;
      vert_1 = vert;
      sag_1 = sag;
      w.frame = last_frame;
      w.average = average;
      w.count = cycles;
      due_q.push_back(w);
    endfunction

    function void check_word(gait_word_t got);
      gait_word_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t ns: word with none expected: strike %b frame %h avg %h count %h",
                 $time, got.strike, got.frame, got.average, got.count);
        return;
      end
      want = due_q.pop_front();
      if (got.strike !== want.strike) begin
        errors++;
        $display("%0t ns: strike expected %b got %b", $time, want.strike, got.strike);
      end
      if (got.frame !== want.frame) begin
        errors++;
        $display("%0t ns: strike_frame expected %h got %h", $time, want.frame, got.frame);
      end
      if (got.average !== want.average) begin
        errors++;
        $display("%0t ns: cycle_avg_us expected %h got %h", $time, want.average, got.average);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t ns: cycle_count expected %h got %h", $time, want.count, got.count);
      end
    endfunction
  endclass

  strike_scoreboard board;
  bit calm = 1'b0;
  bit wild_time = 1'b0;
  int words_sent = 0;
  logic [23:0] frame_no;
  logic [31:0] time_now;
  int vert_pos;
  int sag_pos;

  heel_strike_detector_cycle_average_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [23:0] frame, logic [23:0] vert, logic [23:0] sag,
                           logic [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_number <= frame;
    heel_vertical <= vert;
    heel_sagittal <= sag;
    time_us <= stamp;
    do @(posedge clk); while (in_stall);
    board.note_sample(frame, vert, sag, stamp);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic emit(int dv, int ds);
    frame_no += 24'd1;
    time_now += wild_time ? $urandom() :
                ($urandom_range(0, 49) == 0 ? $urandom_range(1000000, 5000000) :
                                              $urandom_range(8000, 12000));
    vert_pos += dv;
    sag_pos += ds;
    send_word(frame_no, vert_pos[23:0], sag_pos[23:0], time_now);
  endtask

  // rise, plateau, fall to the floor, the touchdown sample, then n_after level samples
  task automatic stride(int n_rise, int n_flat, int n_fall, int amp, int bottom,
                        bit sag_back, int n_after);
    int peak, span, i;
    peak = ((vert_pos > bottom) ? vert_pos : bottom) + amp;
    span = peak - vert_pos;
    for (i = 0; i < n_rise; i++)
      emit((i == n_rise - 1) ? span - (n_rise - 1) * (span / n_rise) : span / n_rise,
           $urandom_range(0, 3000));
    repeat (n_flat) emit(0, int'($urandom_range(0, 1000)) - 500);
    span = peak - bottom;
    for (i = 0; i < n_fall; i++)
      emit((i == n_fall - 1) ? -(span - (n_fall - 1) * (span / n_fall)) : -(span / n_fall),
           int'($urandom_range(0, 1000)) - 500);
    emit($urandom_range(0, 400),
         sag_back ? -int'($urandom_range(0, 600)) : int'($urandom_range(1, 600)));
    repeat (n_after) emit(0, int'($urandom_range(0, 400)) - 200);
  endtask

  task automatic write_reg(logic [hsd_pkg::CfgIdxW-1:0] idx, logic [hsd_pkg::CfgW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic [hsd_pkg::CfgW-1:0] limit, logic [hsd_pkg::CfgW-1:0] margin,
                           bit spare);
    settle();
    if (spare) write_reg(RegSpareA, 23'($urandom()));
    write_reg(hsd_pkg::RegHeightLimit, limit);
    if (spare) write_reg(RegSpareB, 23'($urandom()));
    write_reg(hsd_pkg::RegRiseMargin, margin);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int stop_at, n_rise, n_flat, n_fall, amp, bottom, n_after;
    bit back;
    logic [31:0] a, b, c, d;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      n_rise = $urandom_range(2, 6);
      n_flat = $urandom_range(1, 2);
      n_fall = $urandom_range(3, 7);
      amp = $urandom_range(40000, 300000);
      bottom = int'($urandom_range(0, 250000)) - 150000;
      back = 1'b1;
      n_after = $urandom_range(0, 2);
      case ($urandom_range(0, 99)) inside
        [0:71]: stride(n_rise, n_flat, n_fall, amp, bottom, back, n_after);
        [72:85]: begin
          case (flaw_t'($urandom_range(0, 4)))
            FlawSagForward: back = 1'b0;
            FlawHighHeel: bottom = 100000 + $urandom_range(0, 500000);
            FlawShortFall: n_fall = $urandom_range(1, 2);
            FlawLowPeak: amp = $urandom_range(1, 25000);
            FlawNoPlateau: n_flat = 0;
            default: ;
          endcase
          stride(n_rise, n_flat, n_fall, amp, bottom, back, n_after);
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            a = $urandom();
            b = $urandom();
            c = $urandom();
            d = $urandom();
            send_word(a[23:0], b[23:0], c[23:0], d);
          end
        end
      endcase
    end
  endtask

  initial begin : result_sink
    gait_word_t got;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.strike = strike;
        got.frame = strike_frame;
        got.average = cycle_avg_us;
        got.count = cycle_count;
        board.check_word(got);
      end
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        hold = pick_gap();
        out_stall <= (hold != 0);
        if (hold != 0) hold--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_heel_strike_detector_cycle_average_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    board = new();
    time_now = $urandom();
    vert_pos = 0;
    sag_pos = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 32'hFFFFFFFF);
    send_word(24'h000000, 24'h800000, 24'h7FFFFF, 32'h00000000);
    send_word(24'h000001, 24'h7FFFFF, 24'h7FFFFF, 32'h00000001);
    send_word(24'h800000, 24'h000000, 24'h000000, 32'h80000000);
    // fall starts on frame two, too early to arm there, but it arms on frame three and a touchdown follows
    frame_no = 24'hFFFFFC;
    emit(0, 0);
    emit(0, 0);
    stride(2, 1, 3, 100000, 0, 1'b1, 0);
    // second touchdown lands on frame zero
    frame_no = 24'hFFFFF9;
    stride(2, 1, 3, 100000, 0, 1'b1, 0);
    run_random(170);

    configure(CfgMax, '0, 1'b0);
    run_random(170);

    configure('0, CfgMax, 1'b0);
    run_random(100);

    configure(23'($urandom()), 23'($urandom()), 1'b1);
    run_random(170);

    frame_no = 24'hFFFFFF - 24'($urandom_range(0, 300));
    time_now = 32'hFFFFFFFF - $urandom_range(0, 3000000);
    configure(hsd_pkg::HeightLimitReset, hsd_pkg::RiseMarginReset, 1'b0);
    run_random(170);

    wild_time = 1'b1;
    configure(CfgMax, 23'($urandom_range(0, 30000)), 1'b1);
    run_random(200);

    settle();
    repeat (20) @(posedge clk);
    if (board.errors == 0)
      $display("tb_heel_strike_detector_cycle_average_top OK");
    else
      $display("tb_heel_strike_detector_cycle_average_top NOT OK");
    $finish;
  end
endmodule
